[src/bctm_pkg.sv]
`timescale 1ns / 1ps
package bctm_pkg;

  localparam logic [7:0] KEY_HOUR_UP   = 8'h37;
  localparam logic [7:0] KEY_HOUR_DOWN = 8'h34;
  localparam logic [7:0] KEY_MIN_UP    = 8'h31;
  localparam logic [7:0] KEY_MIN_DOWN  = 8'h2E;
  localparam logic [7:0] KEY_TIMER     = 8'h39;
  localparam logic [7:0] KEY_STOPWATCH = 8'h2F;
  localparam logic [7:0] KEY_ZERO      = 8'h36;
  localparam logic [7:0] KEY_START     = 8'h33;
  localparam logic [7:0] KEY_PAUSE     = 8'h3D;
  localparam logic [7:0] KEY_CLOCK     = 8'h38;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    OP_TICK,
    OP_HOUR_UP,
    OP_HOUR_DOWN,
    OP_MIN_UP,
    OP_MIN_DOWN,
    OP_TIMER,
    OP_STOPWATCH,
    OP_ZERO,
    OP_START,
    OP_PAUSE,
    OP_CLOCK,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    MODE_CLOCK,
    MODE_TIMER,
    MODE_STOPWATCH
  } mode_t;

  // digit 0 is hours tens, digit 5 is seconds units
  typedef logic [0:5][3:0] hms_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_xfer_t;

  localparam hms_t PRESET_RESET = {4'd0, 4'd0, 4'd1, 4'd0, 4'd0, 4'd0};

  function automatic hms_t hours_up(hms_t d);
    hms_t r;
    r = d;
    if ((d[1] < 4'd9 && d[0] < 4'd2) || (d[1] < 4'd3 && d[0] == 4'd2)) begin
      r[1] = d[1] + 4'd1;
    end else if (d[1] == 4'd9) begin
      r[1] = 4'd0;
      r[0] = d[0] + 4'd1;
    end else if (d[2] == 4'd5 && d[3] == 4'd9) begin
      r = '0;
    end else begin
      r[0] = 4'd0;
      r[1] = 4'd0;
    end
    return r;
  endfunction

  function automatic hms_t minutes_up(hms_t d);
    hms_t r;
    r = d;
    if (d[3] < 4'd9) begin
      r[3] = d[3] + 4'd1;
    end else begin
      r[3] = 4'd0;
      if (d[2] < 4'd5) begin
        r[2] = d[2] + 4'd1;
      end else begin
        r[2] = 4'd0;
        r    = hours_up(r);
      end
    end
    return r;
  endfunction

  function automatic hms_t seconds_up(hms_t d);
    hms_t r;
    r = d;
    if (d[5] < 4'd9) begin
      r[5] = d[5] + 4'd1;
    end else begin
      r[5] = 4'd0;
      if (d[4] < 4'd5) begin
        r[4] = d[4] + 4'd1;
      end else begin
        r[4] = 4'd0;
        r    = minutes_up(r);
      end
    end
    return r;
  endfunction

  function automatic hms_t hours_down(hms_t d);
    hms_t r;
    r = d;
    if (d[1] > 4'd0) begin
      r[1] = d[1] - 4'd1;
    end else begin
      r[1] = 4'd9;
      if (d[0] > 4'd0) begin
        r[0] = d[0] - 4'd1;
      end else begin
        r[0] = 4'd2;
        r[1] = 4'd3;
      end
    end
    return r;
  endfunction

  function automatic hms_t minutes_down(hms_t d);
    hms_t r;
    r = d;
    if (d[3] > 4'd0) begin
      r[3] = d[3] - 4'd1;
    end else begin
      r[3] = 4'd9;
      if (d[2] > 4'd0) begin
        r[2] = d[2] - 4'd1;
      end else begin
        r[2] = 4'd5;
        r    = hours_down(r);
      end
    end
    return r;
  endfunction

  function automatic hms_t seconds_down(hms_t d);
    hms_t r;
    r = d;
    if (d[5] > 4'd0) begin
      r[5] = d[5] - 4'd1;
    end else begin
      r[5] = 4'd9;
      if (d[4] > 4'd0) begin
        r[4] = d[4] - 4'd1;
      end else begin
        r[4] = 4'd5;
        r    = minutes_down(r);
      end
    end
    return r;
  endfunction

endpackage

[src/bctm_front.sv]
`timescale 1ns / 1ps
module bctm_front
  import bctm_pkg::*;
(
  input  logic       in_valid,
  input  logic       in_action,
  input  logic [7:0] in_key_code,
  output logic       in_stall,
  input  logic       q_full,
  output op_xfer_t   push
);

  op_t op;

  always_comb begin
    if (!in_action) begin
      op = OP_TICK;
    end else begin
      case (in_key_code)
        KEY_HOUR_UP:   op = OP_HOUR_UP;
        KEY_HOUR_DOWN: op = OP_HOUR_DOWN;
        KEY_MIN_UP:    op = OP_MIN_UP;
        KEY_MIN_DOWN:  op = OP_MIN_DOWN;
        KEY_TIMER:     op = OP_TIMER;
        KEY_STOPWATCH: op = OP_STOPWATCH;
        KEY_ZERO:      op = OP_ZERO;
        KEY_START:     op = OP_START;
        KEY_PAUSE:     op = OP_PAUSE;
        KEY_CLOCK:     op = OP_CLOCK;
        default:       op = OP_NONE;
      endcase
    end
  end

  assign in_stall   = q_full;
  assign push.valid = in_valid && !q_full;
  assign push.op    = op;

endmodule

[src/bctm_queue.sv]
`timescale 1ns / 1ps
module bctm_queue
  import bctm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  op_xfer_t push,
  output logic     full,
  output op_xfer_t head,
  input  logic     pop
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  op_t               mem_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == (PtrW+1)'(QueueDepth));
  assign head.valid = (cnt_r != '0);
  assign head.op    = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({push.valid, do_pop})
      2'b10:   cnt_nxt = cnt_r + (PtrW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (PtrW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.op;
    end
  end

endmodule

[src/bctm_back.sv]
`timescale 1ns / 1ps
module bctm_back
  import bctm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  op_xfer_t   head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_hour_tens,
  output logic [3:0] out_hour_units,
  output logic [2:0] out_minute_tens,
  output logic [3:0] out_minute_units,
  output logic [2:0] out_second_tens,
  output logic [3:0] out_second_units,
  output logic [1:0] out_mode_now,
  output logic       out_running,
  output logic       out_expired
);

  hms_t  shown_r,  shown_nxt;
  hms_t  clock_r,  clock_nxt;
  hms_t  preset_r, preset_nxt;
  mode_t mode_r,   mode_nxt;
  logic  run_r,    run_nxt;
  logic  done_r,   done_nxt;
  logic  out_valid_r, out_valid_nxt;
  hms_t  down;

  assign pop  = head.valid && (!out_valid_r || !out_stall);
  assign down = seconds_down(shown_r);

  always_comb begin
    shown_nxt  = shown_r;
    clock_nxt  = clock_r;
    preset_nxt = preset_r;
    mode_nxt   = mode_r;
    run_nxt    = run_r;
    done_nxt   = done_r;
    if (head.op == OP_TICK) begin
      clock_nxt = seconds_up(clock_r);
      if (mode_r == MODE_CLOCK || (mode_r == MODE_STOPWATCH && run_r)) begin
        shown_nxt = seconds_up(shown_r);
      end else if (mode_r == MODE_TIMER && run_r && !done_r) begin
        shown_nxt = down;
        if (down == '0) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end else begin
      case (mode_r)
        MODE_CLOCK: begin
          case (head.op)
            OP_HOUR_UP: begin
              shown_nxt = hours_up(shown_r);
              clock_nxt = hours_up(clock_r);
            end
            OP_HOUR_DOWN: begin
              shown_nxt = hours_down(shown_r);
              clock_nxt = hours_down(clock_r);
            end
            OP_MIN_UP: begin
              shown_nxt = minutes_up(shown_r);
              clock_nxt = minutes_up(clock_r);
            end
            OP_MIN_DOWN: begin
              shown_nxt = minutes_down(shown_r);
              clock_nxt = minutes_down(clock_r);
            end
            OP_TIMER: begin
              mode_nxt  = MODE_TIMER;
              shown_nxt = preset_r;
              run_nxt   = 1'b0;
              done_nxt  = 1'b0;
            end
            OP_STOPWATCH: begin
              mode_nxt  = MODE_STOPWATCH;
              shown_nxt = '0;
              run_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
        MODE_TIMER: begin
          case (head.op)
            OP_HOUR_UP: begin
              shown_nxt  = hours_up(shown_r);
              preset_nxt = shown_nxt;
            end
            OP_HOUR_DOWN: begin
              shown_nxt  = hours_down(shown_r);
              preset_nxt = shown_nxt;
            end
            OP_MIN_UP: begin
              shown_nxt  = minutes_up(shown_r);
              preset_nxt = shown_nxt;
            end
            OP_MIN_DOWN: begin
              shown_nxt  = minutes_down(shown_r);
              preset_nxt = shown_nxt;
            end
            OP_ZERO: begin
              shown_nxt = preset_r;
              run_nxt   = 1'b0;
              done_nxt  = 1'b0;
            end
            OP_START: run_nxt = 1'b1;
            OP_PAUSE: run_nxt = 1'b0;
            OP_CLOCK: begin
              mode_nxt  = MODE_CLOCK;
              shown_nxt = clock_r;
            end
            OP_STOPWATCH: begin
              mode_nxt  = MODE_STOPWATCH;
              shown_nxt = '0;
              run_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
        MODE_STOPWATCH: begin
          case (head.op)
            OP_ZERO: begin
              shown_nxt = '0;
              run_nxt   = 1'b0;
            end
            OP_START: run_nxt = 1'b1;
            OP_PAUSE: run_nxt = 1'b0;
            OP_CLOCK: begin
              mode_nxt  = MODE_CLOCK;
              shown_nxt = clock_r;
            end
            OP_TIMER: begin
              mode_nxt  = MODE_TIMER;
              shown_nxt = preset_r;
              run_nxt   = 1'b0;
              done_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= '0;
      clock_r     <= '0;
      preset_r    <= PRESET_RESET;
      mode_r      <= MODE_CLOCK;
      run_r       <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        shown_r  <= shown_nxt;
        clock_r  <= clock_nxt;
        preset_r <= preset_nxt;
        mode_r   <= mode_nxt;
        run_r    <= run_nxt;
        done_r   <= done_nxt;
      end
    end
  end

  // result payload, loaded on each transfer from the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      out_hour_tens    <= shown_nxt[0][1:0];
      out_hour_units   <= shown_nxt[1];
      out_minute_tens  <= shown_nxt[2][2:0];
      out_minute_units <= shown_nxt[3];
      out_second_tens  <= shown_nxt[4][2:0];
      out_second_units <= shown_nxt[5];
      out_mode_now     <= mode_nxt;
      out_running      <= run_nxt;
      out_expired      <= done_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/bcd_clock_timer_stopwatch.sv]
`timescale 1ns / 1ps
// 24-hour BCD clock with countdown timer and stopwatch modes.
// Input channel (in_valid / in_stall): each transfer is either a one-second
// tick (in_action = 0) or a keypad press (in_action = 1, code on in_key_code).
// Unknown codes, and codes not meaningful in the current mode, change nothing
// but still produce a result.
// Result channel (out_valid / out_stall): exactly one result per input
// transfer, in order: the six shown digits, the mode, running and expired.
// out_valid rises once an item has passed the queue and the result register;
// one item per cycle is sustained unless the receiver stalls. A two-entry
// queue sits between the key decoder and the state update, and it keeps
// taking items while a result waits. When the receiver stalls, the result
// holds, the queue fills and in_stall rises once both entries are taken.
// Reset (rst_n low, synchronous) clears the time and shown digits, loads the
// timer preset with 00:10:00, selects clock mode, clears running and expired
// and empties the queue.
module bcd_clock_timer_stopwatch
  import bctm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_hour_tens,
  output logic [3:0] out_hour_units,
  output logic [2:0] out_minute_tens,
  output logic [3:0] out_minute_units,
  output logic [2:0] out_second_tens,
  output logic [3:0] out_second_units,
  output logic [1:0] out_mode_now,
  output logic       out_running,
  output logic       out_expired
);

  op_xfer_t push;
  op_xfer_t head;
  logic     q_full;
  logic     pop;

  bctm_front u_front (
    .in_valid    (in_valid),
    .in_action   (in_action),
    .in_key_code (in_key_code),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .push        (push)
  );

  bctm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  bctm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hour_tens    (out_hour_tens),
    .out_hour_units   (out_hour_units),
    .out_minute_tens  (out_minute_tens),
    .out_minute_units (out_minute_units),
    .out_second_tens  (out_second_tens),
    .out_second_units (out_second_units),
    .out_mode_now     (out_mode_now),
    .out_running      (out_running),
    .out_expired      (out_expired)
  );

endmodule

[src/bctm_checker.sv]
`timescale 1ns / 1ps
module bctm_checker
  import bctm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_action,
  input logic [7:0] in_key_code,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_hour_tens,
  input logic [3:0] out_hour_units,
  input logic [2:0] out_minute_tens,
  input logic [3:0] out_minute_units,
  input logic [2:0] out_second_tens,
  input logic [3:0] out_second_units,
  input logic [1:0] out_mode_now,
  input logic       out_running,
  input logic       out_expired
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable({in_action, in_key_code}))
    else $error("stalled input changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid
      && $stable({out_hour_tens, out_hour_units, out_minute_tens, out_minute_units,
                  out_second_tens, out_second_units, out_mode_now, out_running,
                  out_expired}))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour_tens != 2'd3 && out_minute_tens <= 3'd5
      && out_second_tens <= 3'd5 && out_hour_units <= 4'd9
      && out_minute_units <= 4'd9 && out_second_units <= 4'd9)
    else $error("digit out of range");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mode_now != 2'd3)
    else $error("illegal mode shown");

endmodule

bind bcd_clock_timer_stopwatch bctm_checker u_bctm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .in_key_code      (in_key_code),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_hour_tens    (out_hour_tens),
  .out_hour_units   (out_hour_units),
  .out_minute_tens  (out_minute_tens),
  .out_minute_units (out_minute_units),
  .out_second_tens  (out_second_tens),
  .out_second_units (out_second_units),
  .out_mode_now     (out_mode_now),
  .out_running      (out_running),
  .out_expired      (out_expired)
);

[tb/bcd_clock_timer_stopwatch_checker.sv]
`timescale 1ns / 1ps
module bcd_clock_timer_stopwatch_checker
  import bctm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_key_code,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_hour_tens,
  input  logic [3:0] out_hour_units,
  input  logic [2:0] out_minute_tens,
  input  logic [3:0] out_minute_units,
  input  logic [2:0] out_second_tens,
  input  logic [3:0] out_second_units,
  input  logic [1:0] out_mode_now,
  input  logic       out_running,
  input  logic       out_expired,
  output int         fail_count,
  output int         outstanding,
  output hms_t       shown_view
);

  localparam int unsigned HOURS        = 0;
  localparam int unsigned MINUTES      = 2;
  localparam int unsigned SECONDS      = 4;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic [1:0] mode_now;
    logic       running;
    logic       expired;
  } readout_t;

  hms_t     face;
  hms_t     time_of_day;
  hms_t     countdown_preset;
  mode_t    cur_mode;
  logic     counting;
  logic     timed_out;
  readout_t due_readouts[$];
  int       faults = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    shown_view  = '0;
  end

  function automatic hms_t step_up(hms_t d, int unsigned pos);
    hms_t        r;
    int unsigned p;
    r = d;
    p = pos;
    while (p != HOURS) begin
      if (r[p+1] < 4'd9) begin
        r[p+1] = r[p+1] + 4'd1;
        return r;
      end
      r[p+1] = 4'd0;
      if (r[p] < 4'd5) begin
        r[p] = r[p] + 4'd1;
        return r;
      end
      r[p] = 4'd0;
      p = p - 2;
    end
    // 23 with minutes at 59 clears the lot, 23 otherwise goes to 00
    if ((r[1] < 4'd9 && r[0] < 4'd2) || (r[1] < 4'd3 && r[0] == 4'd2)) begin
      r[1] = r[1] + 4'd1;
    end else if (r[1] == 4'd9) begin
      r[1] = 4'd0;
      r[0] = r[0] + 4'd1;
    end else if (r[2] == 4'd5 && r[3] == 4'd9) begin
      r = '0;
    end else begin
      r[0] = 4'd0;
      r[1] = 4'd0;
    end
    return r;
  endfunction

  function automatic hms_t step_down(hms_t d, int unsigned pos);
    hms_t        r;
    int unsigned p;
    r = d;
    p = pos;
    while (p != HOURS) begin
      if (r[p+1] > 4'd0) begin
        r[p+1] = r[p+1] - 4'd1;
        return r;
      end
      r[p+1] = 4'd9;
      if (r[p] > 4'd0) begin
        r[p] = r[p] - 4'd1;
        return r;
      end
      r[p] = 4'd5;
      p = p - 2;
    end
    if (r[1] > 4'd0) begin
      r[1] = r[1] - 4'd1;
    end else if (r[0] > 4'd0) begin
      r[1] = 4'd9;
      r[0] = r[0] - 4'd1;
    end else begin
      r[0] = 4'd2;
      r[1] = 4'd3;
    end
    return r;
  endfunction

  function automatic hms_t adjust(hms_t d, logic [7:0] code);
    case (code)
      KEY_HOUR_UP:   return step_up(d, HOURS);
      KEY_HOUR_DOWN: return step_down(d, HOURS);
      KEY_MIN_UP:    return step_up(d, MINUTES);
      KEY_MIN_DOWN:  return step_down(d, MINUTES);
      default:       return d;
    endcase
  endfunction

  function automatic string readout_text(readout_t r);
    return $sformatf("%0d%0d:%0d%0d:%0d%0d mode %0d run %0b exp %0b",
                     r.hour_tens, r.hour_units, r.minute_tens, r.minute_units,
                     r.second_tens, r.second_units, r.mode_now, r.running, r.expired);
  endfunction

  task automatic enter_timer();
    cur_mode  = MODE_TIMER;
    face      = countdown_preset;
    counting  = 1'b0;
    timed_out = 1'b0;
  endtask

  task automatic enter_stopwatch();
    cur_mode = MODE_STOPWATCH;
    face     = '0;
    counting = 1'b0;
  endtask

  task automatic take_key(logic [7:0] code);
    case (cur_mode)
      MODE_CLOCK: begin
        case (code)
          KEY_HOUR_UP, KEY_HOUR_DOWN, KEY_MIN_UP, KEY_MIN_DOWN: begin
            face        = adjust(face, code);
            time_of_day = adjust(time_of_day, code);
          end
          KEY_TIMER:     enter_timer();
          KEY_STOPWATCH: enter_stopwatch();
          default: ;
        endcase
      end
      MODE_TIMER: begin
        case (code)
          KEY_HOUR_UP, KEY_HOUR_DOWN, KEY_MIN_UP, KEY_MIN_DOWN: begin
            face             = adjust(face, code);
            countdown_preset = face;
          end
          KEY_ZERO: begin
            face      = countdown_preset;
            counting  = 1'b0;
            timed_out = 1'b0;
          end
          KEY_START: counting = 1'b1;
          KEY_PAUSE: counting = 1'b0;
          KEY_CLOCK: begin
            cur_mode = MODE_CLOCK;
            face     = time_of_day;
          end
          KEY_STOPWATCH: enter_stopwatch();
          default: ;
        endcase
      end
      MODE_STOPWATCH: begin
        case (code)
          KEY_ZERO: begin
            face     = '0;
            counting = 1'b0;
          end
          KEY_START: counting = 1'b1;
          KEY_PAUSE: counting = 1'b0;
          KEY_CLOCK: begin
            cur_mode = MODE_CLOCK;
            face     = time_of_day;
          end
          KEY_TIMER: enter_timer();
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic take_tick();
    time_of_day = step_up(time_of_day, SECONDS);
    if (cur_mode == MODE_CLOCK || (cur_mode == MODE_STOPWATCH && counting)) begin
      face = step_up(face, SECONDS);
    end else if (cur_mode == MODE_TIMER && counting && !timed_out) begin
      face = step_down(face, SECONDS);
      if (face == '0) begin
        counting  = 1'b0;
        timed_out = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    if (!rst_n) begin
      face                      = '0;
      time_of_day               = '0;
      countdown_preset          = '0;
      countdown_preset[MINUTES] = 4'd1;
      cur_mode                  = MODE_CLOCK;
      counting                  = 1'b0;
      timed_out                 = 1'b0;
      due_readouts.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_action) begin
          take_key(in_key_code);
        end else begin
          take_tick();
        end
        due_readouts.push_back({face[0][1:0], face[1], face[2][2:0], face[3],
                                face[4][2:0], face[5], cur_mode, counting, timed_out});
      end
      if (out_valid && !out_stall) begin
        got = {out_hour_tens, out_hour_units, out_minute_tens, out_minute_units,
               out_second_tens, out_second_units, out_mode_now, out_running, out_expired};
        if (due_readouts.size() == 0) begin
          if (faults < REPORT_LIMIT) begin
            $display("%0t: result with none due: %s", $time, readout_text(got));
          end
          faults++;
        end else begin
          want = due_readouts.pop_front();
          if (got !== want) begin
            if (faults < REPORT_LIMIT) begin
              $display("%0t: mismatch, expected %s, got %s", $time,
                       readout_text(want), readout_text(got));
            end
            faults++;
          end
        end
      end
    end
    outstanding <= due_readouts.size();
    shown_view  <= face;
    fail_count  <= faults;
  end

endmodule

[tb/bcd_clock_timer_stopwatch_test.sv]
`timescale 1ns / 1ps
module bcd_clock_timer_stopwatch_test;
  import bctm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 60;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic       in_action   = 1'b0;
  logic [7:0] in_key_code = 8'h00;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [1:0] out_hour_tens;
  logic [3:0] out_hour_units;
  logic [2:0] out_minute_tens;
  logic [3:0] out_minute_units;
  logic [2:0] out_second_tens;
  logic [3:0] out_second_units;
  logic [1:0] out_mode_now;
  logic       out_running;
  logic       out_expired;
  int         fail_count;
  int         outstanding;
  hms_t       shown_view;
  int         sent_count  = 0;
  logic       calm        = 1'b0;
  logic       hold_req    = 1'b0;
  logic [7:0] key_set [10] = '{KEY_HOUR_UP, KEY_HOUR_DOWN, KEY_MIN_UP, KEY_MIN_DOWN,
                               KEY_TIMER, KEY_STOPWATCH, KEY_ZERO, KEY_START,
                               KEY_PAUSE, KEY_CLOCK};

  always #4 clk = ~clk;

  bcd_clock_timer_stopwatch DUT (.*);

  bcd_clock_timer_stopwatch_checker watch (.*);

  task automatic send(input logic act, input logic [7:0] code);
    in_valid    <= 1'b1;
    in_action   <= act;
    in_key_code <= code;
    do @(posedge clk); while (in_stall);
    sent_count <= sent_count + 1;
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic press(input logic [7:0] code);
    send(1'b1, code);
  endtask

  task automatic tick();
    send(1'b0, 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic clock_play();
    press(KEY_CLOCK);
    repeat ($urandom_range(20, 4)) begin
      case ($urandom_range(4))
        0: press(KEY_HOUR_UP);
        1: press(KEY_HOUR_DOWN);
        2: press(KEY_MIN_UP);
        3: press(KEY_MIN_DOWN);
        default: tick();
      endcase
    end
  endtask

  // steer the clock to 23:59 then roll over by ticks or clear it with H+
  task automatic midnight_run();
    int unsigned hrs;
    int unsigned mins;
    int unsigned secs;
    press(KEY_CLOCK);
    wait_idle();
    hrs  = 10 * shown_view[0] + shown_view[1];
    mins = 10 * shown_view[2] + shown_view[3];
    secs = 10 * shown_view[4] + shown_view[5];
    if (hrs < 23) repeat (23 - hrs) press(KEY_HOUR_UP);
    if (mins < 59) repeat (59 - mins) press(KEY_MIN_UP);
    if ($urandom_range(1)) begin
      press(KEY_HOUR_UP);
    end else begin
      repeat (60 - secs + $urandom_range(3)) tick();
    end
  endtask

  // bring the preset below three minutes so that the countdown expires
  task automatic timer_run();
    int unsigned hrs;
    int unsigned mins;
    int unsigned secs;
    int unsigned goal;
    int unsigned total;
    int unsigned part;
    press(KEY_CLOCK);
    press(KEY_TIMER);
    wait_idle();
    hrs  = 10 * shown_view[0] + shown_view[1];
    mins = 10 * shown_view[2] + shown_view[3];
    secs = 10 * shown_view[4] + shown_view[5];
    goal = $urandom_range(2);
    repeat (hrs) press(KEY_HOUR_DOWN);
    if (mins > goal) begin
      repeat (mins - goal) press(KEY_MIN_DOWN);
    end else begin
      repeat (goal - mins) press(KEY_MIN_UP);
    end
    total = 60 * goal + secs;
    press(KEY_START);
    if (total == 0) begin
      repeat (3) tick();
    end else begin
      part = $urandom_range(total - 1);
      repeat (part) tick();
      press(KEY_PAUSE);
      repeat (2) tick();
      press(KEY_START);
      repeat (total - part) tick();
      repeat ($urandom_range(3)) tick();
      press(KEY_START);
      repeat (2) tick();
    end
    if ($urandom_range(1)) begin
      press(KEY_ZERO);
    end else begin
      press(KEY_CLOCK);
      press(KEY_TIMER);
    end
  endtask

  task automatic stopwatch_play();
    int unsigned r;
    press(KEY_CLOCK);
    press(KEY_STOPWATCH);
    press(KEY_START);
    repeat ($urandom_range(40, 5)) begin
      r = $urandom_range(99);
      if (r < 75) tick();
      else if (r < 83) press(KEY_PAUSE);
      else if (r < 91) press(KEY_START);
      else if (r < 95) press(KEY_ZERO);
      else press(8'($urandom));
    end
  endtask

  task automatic noise();
    repeat ($urandom_range(8, 2)) begin
      if ($urandom_range(3) == 0) begin
        press(key_set[$urandom_range(9)]);
      end else begin
        send(1'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : receiver
    int unsigned hold_left;
    logic        held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 11);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned base;
    int unsigned pick;
    logic        hold_done;
    hold_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    press(KEY_MIN_DOWN);
    send(1'b0, 8'h00);
    press(KEY_HOUR_UP);
    press(KEY_HOUR_DOWN);
    press(KEY_MIN_UP);
    press(KEY_HOUR_UP);
    press(KEY_MIN_DOWN);
    press(KEY_HOUR_UP);
    press(8'h00);
    press(8'hFF);
    send(1'b0, 8'hFF);
    press(KEY_TIMER);
    press(KEY_START);
    tick();
    press(KEY_PAUSE);
    tick();
    press(KEY_ZERO);
    press(KEY_STOPWATCH);
    press(KEY_START);
    tick();
    press(KEY_ZERO);
    press(KEY_TIMER);
    press(KEY_CLOCK);
    press(KEY_STOPWATCH);
    press(KEY_CLOCK);
    wait_idle();

    base = sent_count;
    while (sent_count < base + RANDOM_ITEMS) begin
      calm <= (sent_count >= base + 600) && (sent_count < base + 800);
      // receiver holds off while ticks keep coming, so the input backs up
      if (!hold_done && sent_count >= base + 300) begin
        hold_done = 1'b1;
        hold_req <= 1'b1;
        repeat (30) tick();
      end
      pick = $urandom_range(99);
      if (pick < 25) clock_play();
      else if (pick < 33) midnight_run();
      else if (pick < 63) timer_run();
      else if (pick < 83) stopwatch_play();
      else noise();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
